// ===== rtl/alle_pkg.sv =====
// ---------------------------------------------------------------------------
// alle_pkg
// Shared widths, codes and controller/datapath structs for the
// array linked list engine.
// ---------------------------------------------------------------------------
package alle_pkg;

    localparam int DEPTH    = 256;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PTR_W    = ADDR_W + 1;
    localparam int DATA_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 8;

    // end-of-list / empty-list pointer
    localparam logic [PTR_W-1:0] PTR_NONE = PTR_W'(DEPTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 2'd0,
        REQ_INS_REAR  = 2'd1,
        REQ_DELETE    = 2'd2
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        DP_NOP    = 3'd0,
        DP_LOAD   = 3'd1,   // capture request, arm scan and walk from head
        DP_SCAN   = 3'd2,   // advance free-slot scan
        DP_INSERT = 3'd3,   // claim scanned slot
        DP_STEP   = 3'd4,   // follow next pointer
        DP_LINK   = 3'd5,   // hook new node after tail
        DP_UNLINK = 3'd6    // drop matching node
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    at_rear;
        logic    res_load;
        t_status res_status;
        logic    slot_from_walk;
    } t_cmd;

    typedef struct packed {
        logic used_at_scan;
        logic scan_last;
        logic head_empty;
        logic nxt_end;
        logic val_match;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/alle_req_if.sv =====
// ---------------------------------------------------------------------------
// alle_req_if
// Request channel: valid/ready with request type and value.
// ---------------------------------------------------------------------------
interface alle_req_if import alle_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ===== rtl/alle_rsp_if.sv =====
// ---------------------------------------------------------------------------
// alle_rsp_if
// Response channel: valid/ready with status and slot index.
// ---------------------------------------------------------------------------
interface alle_rsp_if import alle_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

// ===== rtl/array_linked_list_engine_core.sv =====
// ---------------------------------------------------------------------------
// array_linked_list_engine_core
// Singly linked list kept in a fixed pool of slots with a head pointer.
// ---------------------------------------------------------------------------
// Usage:
//   i_req (sink): req_type 0 inserts value at the front, 1 at the rear,
//   2 deletes the first node from the head holding value; 3 answers
//   not-found. One response per request on o_rsp (source): status 0 done,
//   1 pool full, 2 not found; slot is the slot written or freed, else 0.
// Timing:
//   One request at a time. Inserts scan the valid bits one slot per cycle
//   for the lowest free slot; a rear insert then follows the links one node
//   per cycle to the tail. A delete follows the links one node per cycle
//   until the match or the end of the list. The next request is taken in
//   the cycle after the response is loaded.
//   The walk rate is set by the registered read of the node memories.
// Reset: the pool is empty (all valid bits clear, head empty) after one
//   cycle of i_rst_n low; no clearing pass is needed.
// Stall: a finished response waits in the output register; the next request
//   is taken while it waits, and its own response holds until the transfer.
// ---------------------------------------------------------------------------
module array_linked_list_engine_core import alle_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    alle_req_if.sink   i_req,
    alle_rsp_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    alle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    alle_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_req.value),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_out_status (o_rsp.status),
        .o_out_slot   (o_rsp.slot),
        .o_sts        (sts)
    );

endmodule

// ===== rtl/alle_ctrl.sv =====
// ---------------------------------------------------------------------------
// alle_ctrl
// Request sequencer: free-slot scan, list walk and result handoff.
// ---------------------------------------------------------------------------
module alle_ctrl import alle_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic [REQ_W-1:0] i_req_type,
    output logic             o_req_ready,
    input  t_sts             i_sts,
    output t_cmd             o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WALK = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state    r_state,  n_state;
    t_req_type r_req,    n_req;
    t_status   r_res,    n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_INS_FRONT;
            r_res   <= ST_DONE;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state              = r_state;
        n_req                = r_req;
        n_res                = r_res;
        o_req_ready          = 1'b0;
        o_cmd.op             = DP_NOP;
        o_cmd.at_rear        = (r_req == REQ_INS_REAR);
        o_cmd.res_load       = 1'b0;
        o_cmd.res_status     = r_res;
        o_cmd.slot_from_walk = (r_req == REQ_DELETE);

        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_req    = t_req_type'(i_req_type);
                    case (i_req_type) inside
                        REQ_INS_FRONT, REQ_INS_REAR: begin
                            n_state = S_SCAN;
                        end
                        REQ_DELETE: begin
                            if (i_sts.head_empty) begin
                                n_res   = ST_NOT_FOUND;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_res   = ST_NOT_FOUND;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!i_sts.used_at_scan) begin
                    o_cmd.op = DP_INSERT;
                    if (o_cmd.at_rear && !i_sts.head_empty) begin
                        n_state = S_WALK;
                    end else begin
                        n_res   = ST_DONE;
                        n_state = S_RESP;
                    end
                end else if (i_sts.scan_last) begin
                    n_res   = ST_FULL;
                    n_state = S_RESP;
                end else begin
                    o_cmd.op = DP_SCAN;
                end
            end
            S_WALK: begin
                if (r_req == REQ_DELETE) begin
                    if (i_sts.val_match) begin
                        o_cmd.op = DP_UNLINK;
                        n_res    = ST_DONE;
                        n_state  = S_RESP;
                    end else if (i_sts.nxt_end) begin
                        n_res   = ST_NOT_FOUND;
                        n_state = S_RESP;
                    end else begin
                        o_cmd.op = DP_STEP;
                    end
                end else begin
                    if (i_sts.nxt_end) begin
                        o_cmd.op = DP_LINK;
                        n_res    = ST_DONE;
                        n_state  = S_RESP;
                    end else begin
                        o_cmd.op = DP_STEP;
                    end
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/alle_dp.sv =====
// ---------------------------------------------------------------------------
// alle_dp
// Node pool storage, head pointer, walk pointers and result register.
// ---------------------------------------------------------------------------
module alle_dp import alle_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [STATUS_W-1:0]      o_out_status,
    output logic [SLOT_W-1:0]        o_out_slot,
    output t_sts                     o_sts
);

    logic [DATA_W-1:0] mem_val [DEPTH];
    logic [PTR_W-1:0]  mem_nxt [DEPTH];

    logic [DEPTH-1:0]  r_used;
    logic [PTR_W-1:0]  r_head;
    logic [DATA_W-1:0] r_value;
    logic [ADDR_W-1:0] r_scan;
    logic [ADDR_W-1:0] r_s;
    logic [PTR_W-1:0]  r_p;
    logic [PTR_W-1:0]  r_prev;
    logic [DATA_W-1:0] r_val_q;
    logic [PTR_W-1:0]  r_nxt_q;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [SLOT_W-1:0] r_out_slot;

    logic [ADDR_W-1:0] rd_addr;
    logic              nxt_we;
    logic [ADDR_W-1:0] nxt_wa;
    logic [PTR_W-1:0]  nxt_wd;
    logic              head_empty;
    logic [SLOT_W-1:0] res_slot;

    assign head_empty = (r_head == PTR_NONE);

    // read address: start at head on load/insert, follow the link on a step
    always_comb begin
        case (i_cmd.op)
            DP_LOAD, DP_INSERT: rd_addr = r_head[ADDR_W-1:0];
            DP_STEP:            rd_addr = r_nxt_q[ADDR_W-1:0];
            default:            rd_addr = r_p[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        nxt_we = 1'b0;
        nxt_wa = r_scan;
        nxt_wd = PTR_NONE;
        case (i_cmd.op)
            DP_INSERT: begin
                nxt_we = 1'b1;
                nxt_wa = r_scan;
                nxt_wd = i_cmd.at_rear ? PTR_NONE : r_head;
            end
            DP_LINK: begin
                nxt_we = 1'b1;
                nxt_wa = r_p[ADDR_W-1:0];
                nxt_wd = PTR_W'(r_s);
            end
            DP_UNLINK: begin
                nxt_we = (r_prev != PTR_NONE);
                nxt_wa = r_prev[ADDR_W-1:0];
                nxt_wd = r_nxt_q;
            end
            default: begin
                nxt_we = 1'b0;
            end
        endcase
    end

    // node storage, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_INSERT) begin
            mem_val[r_scan] <= r_value;
        end
        if (nxt_we) begin
            mem_nxt[nxt_wa] <= nxt_wd;
        end
        r_val_q <= mem_val[rd_addr];
        r_nxt_q <= mem_nxt[rd_addr];
    end

    // walk and scan pointers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_value <= i_value;
                r_scan  <= '0;
                r_p     <= r_head;
                r_prev  <= PTR_NONE;
            end
            DP_SCAN: begin
                r_scan <= r_scan + ADDR_W'(1);
            end
            DP_INSERT: begin
                r_s    <= r_scan;
                r_p    <= r_head;
                r_prev <= PTR_NONE;
            end
            DP_STEP: begin
                r_prev <= r_p;
                r_p    <= r_nxt_q;
            end
            default: begin
            end
        endcase
    end

    // valid bits and head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_head <= PTR_NONE;
        end else begin
            case (i_cmd.op)
                DP_INSERT: begin
                    r_used[r_scan] <= 1'b1;
                    if (!i_cmd.at_rear || head_empty) begin
                        r_head <= PTR_W'(r_scan);
                    end
                end
                DP_UNLINK: begin
                    r_used[r_p[ADDR_W-1:0]] <= 1'b0;
                    if (r_prev == PTR_NONE) begin
                        r_head <= r_nxt_q;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (i_cmd.res_status != ST_DONE) begin
            res_slot = '0;
        end else if (i_cmd.slot_from_walk) begin
            res_slot = SLOT_W'(r_p[ADDR_W-1:0]);
        end else begin
            res_slot = SLOT_W'(r_s);
        end
    end

    // result register; holds until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_status <= i_cmd.res_status;
            r_out_slot   <= res_slot;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_slot   = r_out_slot;

    assign o_sts.used_at_scan = r_used[r_scan];
    assign o_sts.scan_last    = (r_scan == ADDR_W'(DEPTH - 1));
    assign o_sts.head_empty   = head_empty;
    assign o_sts.nxt_end      = (r_nxt_q == PTR_NONE);
    assign o_sts.val_match    = (r_val_q == r_value);
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

`ifndef SYNTHESIS
    a_head_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !head_empty |-> r_used[r_head[ADDR_W-1:0]])
        else $error("head points at a free slot");

    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_INSERT |-> !r_used[r_scan])
        else $error("insert claims a slot in use");

    a_unlink_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_UNLINK |-> (r_val_q == r_value) && r_used[r_p[ADDR_W-1:0]])
        else $error("unlink of a non-matching or free node");

    a_full_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load && i_cmd.res_status == ST_FULL |-> &r_used)
        else $error("full reported with a free slot");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> !r_out_valid || i_out_ready)
        else $error("result overwritten before transfer");
`endif

endmodule
